@@ hdl/bsra_pkg.sv @@
package bsra_pkg;

    typedef logic [1:0]  op_t;
    typedef logic [5:0]  len_t;
    typedef logic [11:0] sector_t;
    typedef logic [4:0]  bad_cnt_t;
    typedef logic [8:0]  bad_byte_t;
    typedef logic [2:0]  bad_bit_t;

    localparam op_t OP_FIND  = 2'd0;
    localparam op_t OP_ALLOC = 2'd1;
    localparam op_t OP_FREE  = 2'd2;

    localparam int         MAP_BYTES      = 512;
    localparam int         BAD_TABLE_SIZE = 16;
    localparam logic [7:0] FULL_BYTE = 8'hFF;
    localparam int         MAX_RUN   = 32;
    localparam int         LEN_LIMIT = 33;

endpackage

@@ hdl/bitmap_sector_run_allocator.sv @@
// First-fit sector run allocator over a free map and an allocation map.
// Input channel (item_valid / item_stall) carries one word: operation and
// run_length. Output channel (result_valid / result_stall) carries one word
// per input word: success, start_sector, bad_count, first_bad_byte and
// first_bad_bit.
// Both maps live in one synchronous memory, one map byte pair per row, one
// row read per cycle. Find scans rows from zero until the run completes.
// Allocate and free update up to nine rows, each read and then written,
// then scan every row for the complement check. A bad length or an
// unknown operation goes straight to the result. The row scan sets the
// rate. After reset the block writes every row (all free, none allocated),
// one row a cycle, and holds item_stall high until done.
// One item is in work at a time; item_stall is high while it runs. The
// finished word goes into an output register; while the receiver stalls,
// the next item may be taken and worked, and only its final word waits
// until the register frees.
module bitmap_sector_run_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  bsra_pkg::op_t       operation,
    input  bsra_pkg::len_t      run_length,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                success,
    output bsra_pkg::sector_t   start_sector,
    output bsra_pkg::bad_cnt_t  bad_count,
    output bsra_pkg::bad_byte_t first_bad_byte,
    output bsra_pkg::bad_bit_t  first_bad_bit
);
    import bsra_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int SW = AW + 3;
    localparam int CW = $clog2(BAD_TABLE_SIZE + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_MVRD  = 3'd3;
    localparam logic [2:0] S_MVWR  = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [15:0] mem [MAP_BYTES];
    logic [15:0] rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [15:0] mem_wdata;

    logic [2:0]  state_reg, state_next;
    logic [AW:0] scan_addr_reg, scan_addr_next;
    logic        rd_vld_reg, rd_vld_next;
    logic [AW-1:0] proc_addr_reg, proc_addr_next;
    logic [5:0]  run_reg, run_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] fbyte_reg, fbyte_next;
    logic [2:0]  fbit_reg, fbit_next;
    logic [9:0]  mv_byte_reg, mv_byte_next;
    logic [9:0]  mv_last_reg, mv_last_next;
    logic        mv_alloc_reg, mv_alloc_next;
    sector_t     pstart_reg, pstart_next;
    logic        pvalid_reg, pvalid_next;
    len_t        pcount_reg, pcount_next;
    logic        res_ok_reg, res_ok_next;
    sector_t     res_start_reg, res_start_next;
    logic        result_valid_reg, result_valid_next;
    logic        success_reg;
    sector_t     start_sector_reg;
    logic [CW-1:0] bad_count_reg;
    logic [AW-1:0] first_bad_byte_reg;
    logic [2:0]  first_bad_bit_reg;
    logic        load_out;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        logic [5:0]    run_v;
        logic          found_v;
        logic [SW-1:0] sec_v;
        logic [SW-1:0] st_v;
        logic [7:0]    x_v;
        logic [2:0]    tb_v;
        logic          stop_v;
        logic [7:0]    mask_v;
        logic [12:0]   bsec_v;
        logic [12:0]   pend_end_v;
        logic          chk_start;

        state_next        = state_reg;
        scan_addr_next    = scan_addr_reg;
        rd_vld_next       = 1'b0;
        proc_addr_next    = proc_addr_reg;
        run_next          = run_reg;
        cnt_next          = cnt_reg;
        fbyte_next        = fbyte_reg;
        fbit_next         = fbit_reg;
        mv_byte_next      = mv_byte_reg;
        mv_last_next      = mv_last_reg;
        mv_alloc_next     = mv_alloc_reg;
        pstart_next       = pstart_reg;
        pvalid_next       = pvalid_reg;
        pcount_next       = pcount_reg;
        res_ok_next       = res_ok_reg;
        res_start_next    = res_start_reg;
        result_valid_next = result_valid_reg & result_stall;
        load_out          = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = scan_addr_reg[AW-1:0];
        mem_wdata         = {8'h00, FULL_BYTE};
        mem_raddr         = scan_addr_reg[AW-1:0];
        run_v             = run_reg;
        found_v           = 1'b0;
        sec_v             = '0;
        st_v              = '0;
        x_v               = '0;
        tb_v              = '0;
        stop_v            = 1'b0;
        mask_v            = '0;
        bsec_v            = '0;
        pend_end_v        = 13'(pstart_reg) + 13'(pcount_reg);
        chk_start         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (32'(scan_addr_reg) >= MAP_BYTES - 1)
                begin
                    scan_addr_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + (AW+1)'(1);
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    res_ok_next    = 1'b0;
                    res_start_next = '0;
                    cnt_next       = '0;
                    fbyte_next     = '0;
                    fbit_next      = '0;
                    case (operation)
                        OP_FIND:
                        begin
                            pcount_next = run_length;
                            if (run_length != '0 && 32'(run_length) < LEN_LIMIT
                                && 32'(run_length) <= MAX_RUN)
                            begin
                                pvalid_next    = 1'b0;
                                pstart_next    = '0;
                                scan_addr_next = '0;
                                run_next       = '0;
                                state_next     = S_FIND;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        OP_ALLOC, OP_FREE:
                        begin
                            mv_alloc_next = (operation == OP_ALLOC);
                            if (pvalid_reg && pcount_reg != '0)
                            begin
                                mv_byte_next = 10'(pstart_reg >> 3);
                                mv_last_next = 10'((pend_end_v - 13'd1) >> 3);
                                state_next   = S_MVRD;
                            end
                            else
                            begin
                                chk_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (32'(scan_addr_reg) < MAP_BYTES)
                begin
                    scan_addr_next = scan_addr_reg + (AW+1)'(1);
                    rd_vld_next    = 1'b1;
                    proc_addr_next = scan_addr_reg[AW-1:0];
                end
                if (rd_vld_reg)
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        if (!found_v)
                        begin
                            run_v = rd_data_reg[j] ? run_v + 6'd1 : 6'd0;
                            if (run_v == pcount_reg)
                            begin
                                found_v = 1'b1;
                                sec_v   = {proc_addr_reg, 3'(j)};
                            end
                        end
                    end
                    run_next = run_v;
                    if (found_v)
                    begin
                        st_v           = sec_v + SW'(1) - SW'(pcount_reg);
                        res_ok_next    = 1'b1;
                        res_start_next = sector_t'(st_v);
                        pstart_next    = sector_t'(st_v);
                        pvalid_next    = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (32'(proc_addr_reg) == MAP_BYTES - 1)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MVRD:
            begin
                if (32'(mv_byte_reg) >= MAP_BYTES)
                begin
                    chk_start = 1'b1;
                end
                else
                begin
                    mem_raddr  = AW'(mv_byte_reg);
                    state_next = S_MVWR;
                end
            end
            S_MVWR:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    bsec_v    = {mv_byte_reg, 3'(j)};
                    mask_v[j] = (bsec_v >= 13'(pstart_reg)) && (bsec_v < pend_end_v);
                end
                mem_we    = 1'b1;
                mem_waddr = AW'(mv_byte_reg);
                if (mv_alloc_reg)
                begin
                    mem_wdata = {rd_data_reg[15:8] | mask_v, rd_data_reg[7:0] & ~mask_v};
                end
                else
                begin
                    mem_wdata = {rd_data_reg[15:8] & ~mask_v, rd_data_reg[7:0] | mask_v};
                end
                if (mv_byte_reg == mv_last_reg)
                begin
                    chk_start = 1'b1;
                end
                else
                begin
                    mv_byte_next = mv_byte_reg + 10'd1;
                    state_next   = S_MVRD;
                end
            end
            S_CHK:
            begin
                if (32'(scan_addr_reg) < MAP_BYTES)
                begin
                    scan_addr_next = scan_addr_reg + (AW+1)'(1);
                    rd_vld_next    = 1'b1;
                    proc_addr_next = scan_addr_reg[AW-1:0];
                end
                if (rd_vld_reg)
                begin
                    x_v = rd_data_reg[7:0] ^ rd_data_reg[15:8];
                    for (int j = 0; j < 8; j++)
                    begin
                        if (!stop_v && x_v[j])
                        begin
                            tb_v = tb_v + 3'd1;
                        end
                        else
                        begin
                            stop_v = 1'b1;
                        end
                    end
                    if (x_v != FULL_BYTE)
                    begin
                        if (cnt_reg == '0)
                        begin
                            fbyte_next = proc_addr_reg;
                            fbit_next  = tb_v;
                        end
                        if (cnt_reg < CW'(BAD_TABLE_SIZE))
                        begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    if (32'(proc_addr_reg) == MAP_BYTES - 1)
                    begin
                        state_next = S_DONE;
                        if (cnt_next == '0)
                        begin
                            res_ok_next = 1'b1;
                            pstart_next = '0;
                            pvalid_next = 1'b0;
                            pcount_next = '0;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out          = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (chk_start)
        begin
            scan_addr_next = '0;
            cnt_next       = '0;
            fbyte_next     = '0;
            fbit_next      = '0;
            state_next     = S_CHK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            scan_addr_reg    <= '0;
            rd_vld_reg       <= 1'b0;
            pstart_reg       <= '0;
            pvalid_reg       <= 1'b0;
            pcount_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_addr_reg    <= scan_addr_next;
            rd_vld_reg       <= rd_vld_next;
            pstart_reg       <= pstart_next;
            pvalid_reg       <= pvalid_next;
            pcount_reg       <= pcount_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_addr_reg <= proc_addr_next;
        run_reg       <= run_next;
        cnt_reg       <= cnt_next;
        fbyte_reg     <= fbyte_next;
        fbit_reg      <= fbit_next;
        mv_byte_reg   <= mv_byte_next;
        mv_last_reg   <= mv_last_next;
        mv_alloc_reg  <= mv_alloc_next;
        res_ok_reg    <= res_ok_next;
        res_start_reg <= res_start_next;
        if (load_out)
        begin
            success_reg        <= res_ok_reg;
            start_sector_reg   <= res_start_reg;
            bad_count_reg      <= cnt_reg;
            first_bad_byte_reg <= fbyte_reg;
            first_bad_bit_reg  <= fbit_reg;
        end
    end

    assign item_stall     = (state_reg != S_IDLE);
    assign result_valid   = result_valid_reg;
    assign success        = success_reg;
    assign start_sector   = start_sector_reg;
    assign bad_count      = bad_cnt_t'(bad_count_reg);
    assign first_bad_byte = bad_byte_t'(first_bad_byte_reg);
    assign first_bad_bit  = first_bad_bit_reg;

    a_mem_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_MVWR))
        else $error("map write outside clear or update");

    a_cnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (32'(cnt_reg) <= BAD_TABLE_SIZE))
        else $error("bad byte count past table size");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result word raised outside completion");

    a_find_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND && state_next == S_DONE && res_ok_next)
        |=> pvalid_reg && pstart_reg == res_start_reg)
        else $error("found run not held as pending");

endmodule
